/* rtl/pwmpc_pkg.sv */
package pwmpc_pkg;

    // Fixed field widths of the input and result items.
    localparam int FREQ_W   = 24;
    localparam int DUTY_W   = 17;
    localparam int SHIFT_W  = 3;
    localparam int COUNT_W  = 15;
    localparam int STATUS_W = 2;

    // Largest period count and largest prescale shift; the result field widths
    // above are sized for exactly these limits.
    localparam int MAX_PERIOD = 32767;
    localparam int MAX_SHIFT  = 7;

    // Q16 representation of a duty of exactly one.
    localparam logic [DUTY_W-1:0] Q16_ONE = 17'd65536;
    localparam int Q16_FRAC = 16;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREQ = 2'd2;

    // Control fields that travel alongside the divider data.
    typedef struct packed {
        logic                valid;
        logic [SHIFT_W-1:0]  shift;
        logic [STATUS_W-1:0] status;
        logic [DUTY_W-1:0]   duty;
    } pwmpc_ctl_t;

    // One finished result.
    typedef struct packed {
        logic [SHIFT_W-1:0]  shift;
        logic [COUNT_W-1:0]  period;
        logic [COUNT_W-1:0]  duty;
        logic [STATUS_W-1:0] status;
    } pwmpc_res_t;

endpackage

/* rtl/pwmpc_front.sv */
module pwmpc_front #(
    parameter int CLOCK_HZ   = 16000000
) (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  logic                                               en,
    input  logic                                               in_valid,
    input  logic [pwmpc_pkg::FREQ_W-1:0]                       freq_hz,
    input  logic [pwmpc_pkg::DUTY_W-1:0]                       duty_fraction,
    output pwmpc_pkg::pwmpc_ctl_t                              ctl_reg,
    output logic [pwmpc_pkg::FREQ_W+pwmpc_pkg::MAX_SHIFT-1:0]  denom_reg
);
    import pwmpc_pkg::*;

    localparam int DENW    = FREQ_W + MAX_SHIFT;
    localparam int SHW     = $clog2(MAX_SHIFT + 1);
    // Smallest divisor for which the period count stays at or below the maximum.
    localparam int MIN_DEN = (CLOCK_HZ + MAX_PERIOD - 1) / MAX_PERIOD;

    logic [SHW-1:0]   shift_sel;
    logic             found;
    logic [DENW-1:0]  freq_ext;
    pwmpc_ctl_t       ctl_next;
    logic [DENW-1:0]  denom_next;

    assign freq_ext = DENW'(freq_hz);

    // Every shift is tested in parallel; the lowest passing shift wins.
    always_comb begin
        shift_sel = '0;
        found     = 1'b0;
        for (int s = MAX_SHIFT; s >= 0; s--) begin
            if ((freq_ext << s) >= DENW'(MIN_DEN)) begin
                found     = 1'b1;
                shift_sel = SHW'(s);
            end
        end
    end

    always_comb begin
        ctl_next.valid = in_valid;
        ctl_next.duty  = duty_fraction;
        ctl_next.shift = '0;
        denom_next     = freq_ext << shift_sel;
        if (duty_fraction > Q16_ONE) begin
            ctl_next.status = ST_DUTY;
        end else if (!found) begin
            ctl_next.status = ST_FREQ;
        end else begin
            ctl_next.status = ST_OK;
            ctl_next.shift  = SHIFT_W'(shift_sel);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            denom_reg <= denom_next;
        end
    end

endmodule

/* rtl/pwmpc_cell.sv */
module pwmpc_cell #(
    parameter int CLKW    = 24,
    parameter int DENW    = 31,
    parameter int QW      = 15,
    parameter int BIT_POS = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  pwmpc_pkg::pwmpc_ctl_t ctl_in,
    input  logic [DENW-1:0]       denom_in,
    input  logic [CLKW-1:0]       rem_in,
    input  logic [QW-1:0]         quot_in,
    output pwmpc_pkg::pwmpc_ctl_t ctl_reg,
    output logic [DENW-1:0]       denom_reg,
    output logic [CLKW-1:0]       rem_reg,
    output logic [QW-1:0]         quot_reg
);
    import pwmpc_pkg::*;

    localparam int CW = (CLKW > DENW) ? CLKW : DENW;

    logic [CLKW-1:0]    rem_sh;
    logic [DENW+QW-1:0] den_sh;
    logic               ge;
    logic [CLKW-1:0]    rem_next;
    logic [QW-1:0]      quot_next;

    // One restoring step: try to take the divisor, scaled to this bit, off the remainder.
    assign rem_sh    = rem_in >> BIT_POS;
    assign ge        = CW'(rem_sh) >= CW'(denom_in);
    assign den_sh    = (DENW + QW)'(denom_in) << BIT_POS;
    assign rem_next  = ge ? (rem_in - CLKW'(den_sh)) : rem_in;
    assign quot_next = {quot_in[QW-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            denom_reg <= denom_in;
            rem_reg   <= rem_next;
            quot_reg  <= quot_next;
        end
    end

endmodule

/* rtl/pwmpc_duty.sv */
module pwmpc_duty #(
    parameter int QW = 15
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  pwmpc_pkg::pwmpc_ctl_t ctl_in,
    input  logic [QW-1:0]         quot_in,
    output logic                  valid_reg,
    output pwmpc_pkg::pwmpc_res_t res_reg
);
    import pwmpc_pkg::*;

    logic [DUTY_W+QW-1:0] prod;
    pwmpc_res_t           res_next;

    assign prod = (DUTY_W + QW)'(ctl_in.duty) * (DUTY_W + QW)'(quot_in);

    // Errors report zero counts and a zero shift.
    always_comb begin
        res_next.status = ctl_in.status;
        if (ctl_in.status == ST_OK) begin
            res_next.shift  = ctl_in.shift;
            res_next.period = COUNT_W'(quot_in);
            res_next.duty   = COUNT_W'(prod >> Q16_FRAC);
        end else begin
            res_next.shift  = '0;
            res_next.period = '0;
            res_next.duty   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

endmodule

/* rtl/pwm_prescale_period_calc.sv */
// PWM prescale and period calculator.
// Each input item on the s_ channel carries a target PWM frequency in hertz and a
// duty fraction in Q16. The block returns one result item per input item on the m_
// channel: the power-of-two prescale shift, the floored period count, the duty
// compare count, and a status code in m_tuser (ok, duty above one, or frequency zero
// or too low; errors return zero counts).
// The shift is chosen in a front stage, the period comes from a row of restoring
// divider cells with one cell per quotient bit, and a last stage forms the duty count
// with one multiply. An accepted input item passes through the front stage, 15
// divider cells, the duty stage and the output register before it shows on m_tvalid.
// Throughput is one item per cycle while the skid register is free, as the divider
// row advances only then.
// The result side has an output register and a one-entry skid register. When the
// receiver stalls, the pipeline keeps moving until a result lands in the skid
// register; s_tready then drops and the whole pipeline holds until the receiver
// takes an item. Reset clears every valid flag and leaves no item in flight; the
// block is ready for input as soon as reset is released.
module pwm_prescale_period_calc #(
    parameter int CLOCK_HZ   = 16000000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // [23:0] freq_hz, [40:24] duty_fraction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [2:0] prescale_shift, [17:3] period_count,
                                  // [32:18] duty_count
    output logic [1:0]  m_tuser   // [1:0] status
);
    import pwmpc_pkg::*;

    localparam int DENW = FREQ_W + MAX_SHIFT;
    localparam int CLKW = $clog2(CLOCK_HZ + 1);
    localparam int QW   = $clog2(MAX_PERIOD + 1);

    // Data handed from cell to cell; entry 0 holds the front stage output and the start values.
    pwmpc_ctl_t      ctl_a   [QW+1];
    logic [DENW-1:0] denom_a [QW+1];
    logic [CLKW-1:0] rem_a   [QW+1];
    logic [QW-1:0]   quot_a  [QW+1];

    logic       en;
    logic       fin_valid;
    pwmpc_res_t fin_res;
    logic       take;

    logic       out_valid_reg;
    pwmpc_res_t out_res_reg;
    logic       skid_valid_reg;
    pwmpc_res_t skid_res_reg;

    // The pipeline advances whenever the skid register is free.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    pwmpc_front #(
        .CLOCK_HZ   (CLOCK_HZ)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_tvalid),
        .freq_hz       (s_tdata[FREQ_W-1:0]),
        .duty_fraction (s_tdata[FREQ_W+DUTY_W-1:FREQ_W]),
        .ctl_reg       (ctl_a[0]),
        .denom_reg     (denom_a[0])
    );

    // The remainder starts as the clock rate and the quotient as zero.
    assign rem_a[0]  = CLKW'(CLOCK_HZ);
    assign quot_a[0] = '0;

    // Cell i decides quotient bit QW-1-i, most significant first.
    for (genvar i = 0; i < QW; i++) begin : g_cell
        pwmpc_cell #(
            .CLKW    (CLKW),
            .DENW    (DENW),
            .QW      (QW),
            .BIT_POS (QW - 1 - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .ctl_in    (i == 0 ? ctl_a[0] : ctl_a[i]),
            .denom_in  (denom_a[i]),
            .rem_in    (rem_a[i]),
            .quot_in   (quot_a[i]),
            .ctl_reg   (ctl_a[i+1]),
            .denom_reg (denom_a[i+1]),
            .rem_reg   (rem_a[i+1]),
            .quot_reg  (quot_a[i+1])
        );
    end

    pwmpc_duty #(
        .QW (QW)
    ) u_duty (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .ctl_in    (ctl_a[QW]),
        .quot_in   (quot_a[QW]),
        .valid_reg (fin_valid),
        .res_reg   (fin_res)
    );

    // A finished result leaves the pipeline only in a cycle in which it advances.
    assign take = en && fin_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= take;
            end
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_res_reg <= skid_res_reg;
            end else if (take) begin
                out_res_reg <= fin_res;
            end
        end else if (take) begin
            skid_res_reg <= fin_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.duty, out_res_reg.period, out_res_reg.shift};
    assign m_tuser  = out_res_reg.status;

endmodule
